>>> sv/retry_queue_backoff_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Retry queue assertion macros
// Concurrent assertion wrappers, removable by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RETRY_QUEUE_BACKOFF_SCHEDULER_DEFINES_SVH
`define RETRY_QUEUE_BACKOFF_SCHEDULER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/rqbs_pkg.sv
// ----------------------------------------------------------------------------
// Retry queue package
// Shared widths, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none
package rqbs_pkg;
	localparam int unsigned SLOTS_DEF = 16;
	localparam int unsigned MAX_ATTEMPTS = 16;
	localparam logic [30:0] MAX_AGE_RST = 31'd600000;
	localparam logic [3:0] MAX_RETRIES_RST = 4'd3;
	localparam logic [15:0] BASE_BACKOFF_RST = 16'd5000;

	localparam logic [1:0] CMD_ENQ = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_ROUTE = 2'd2;

	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_ATT = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_ROUTE = 2'd3;

	localparam logic [1:0] OUT_OK = 2'd0;
	localparam logic [1:0] OUT_KEEP = 2'd1;
	localparam logic [1:0] OUT_DROP = 2'd2;
	localparam logic [1:0] OUT_EVICT = 2'd1;

	localparam logic [1:0] REG_MAX_AGE = 2'd0;
	localparam logic [1:0] REG_MAX_RETRIES = 2'd1;
	localparam logic [1:0] REG_BASE_BACKOFF = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [31:0] now_ms;
		logic [15:0] dest_address;
		logic [31:0] message_id;
		logic [31:0] packet_tag;
		logic [15:0] send_ok_mask;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] slot;
		logic [15:0] out_dest_address;
		logic [31:0] out_message_id;
		logic [31:0] out_packet_tag;
		logic [1:0] outcome;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic load;      // capture input item, start scan
		logic scan_step; // visit next slot in scan
		logic do_enq;    // write chosen enqueue slot
		logic do_route;  // mark route-found slots
		logic pick;      // choose oldest unvisited slot
		logic visit;     // evaluate picked slot
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic any_left;
		logic attempt;
	} dp_sts_t;
endpackage
`default_nettype wire

>>> sv/rqbs_stream_if.sv
// ----------------------------------------------------------------------------
// Retry queue stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface rqbs_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/rqbs_datapath.sv
// ----------------------------------------------------------------------------
// Retry queue datapath
// Slot table, age scan, expiry, backoff and attempt evaluation.
// ----------------------------------------------------------------------------
`default_nettype none
module rqbs_datapath
	import rqbs_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dp_cmd_t cmd,
	output dp_sts_t sts,
	input wire in_item_t item,
	input wire logic [30:0] max_age_ms,
	input wire logic [3:0] max_retries,
	input wire logic [15:0] base_backoff_ms,
	output out_item_t res
);
	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] seen_q;
	logic [31:0] stime_q [SLOTS];
	logic [31:0] ltry_q [SLOTS];
	logic [SLOTS-1:0] trynow_q;
	logic [4:0] fail_q [SLOTS];
	logic [15:0] dest_q [SLOTS];
	logic [31:0] mid_q [SLOTS];
	logic [31:0] tag_q [SLOTS];

	in_item_t item_q;
	logic [IW:0] idx_q;
	logic [IW-1:0] best_q;
	logic [31:0] best_age_q;
	logic best_vld_q;
	logic found_free_q;
	logic [IW-1:0] free_q;
	logic [4:0] att_q;
	logic attempt_q;

	logic [IW-1:0] cur;
	logic [31:0] cur_age;
	logic [31:0] b_age;
	logic [31:0] delay;
	logic expired;
	logic in_window;
	logic ok;
	logic [4:0] fail_nx;

	assign cur = idx_q[IW-1:0];
	assign cur_age = item_q.now_ms - stime_q[cur];
	assign b_age = item_q.now_ms - stime_q[best_q];
	assign delay = 32'({16'd0, base_backoff_ms} << fail_q[best_q]);
	assign expired = !b_age[31] && (b_age >= {1'b0, max_age_ms});
	assign in_window = !trynow_q[best_q] && ((item_q.now_ms - ltry_q[best_q]) < delay);
	assign ok = (32'(best_q) < 32'd16) && item_q.send_ok_mask[4'(best_q)];
	assign fail_nx = (fail_q[best_q] < 5'd31) ? fail_q[best_q] + 5'd1 : fail_q[best_q];

	assign sts.scan_done = (32'(idx_q) >= SLOTS - 1);
	assign sts.any_left = best_vld_q;
	assign sts.attempt = attempt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seen_q <= '0;
			idx_q <= '0;
			best_vld_q <= 1'b0;
			found_free_q <= 1'b0;
			att_q <= '0;
			attempt_q <= 1'b0;
		end else begin
			attempt_q <= 1'b0;
			if (cmd.load) begin
				item_q <= item;
				idx_q <= '0;
				seen_q <= '0;
				att_q <= '0;
				found_free_q <= 1'b0;
				best_vld_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (!valid_q[cur]) begin
					if (!found_free_q) begin
						found_free_q <= 1'b1;
						free_q <= cur;
					end
				end else if (!best_vld_q || cur_age > best_age_q) begin
					best_vld_q <= 1'b1;
					best_q <= cur;
					best_age_q <= cur_age;
				end
			end
			if (cmd.pick) begin
				idx_q <= idx_q + 1'b1;
				if (valid_q[cur] && !seen_q[cur]
						&& (!best_vld_q || cur_age > best_age_q)) begin
					best_vld_q <= 1'b1;
					best_q <= cur;
					best_age_q <= cur_age;
				end
			end
			if (cmd.do_enq) begin
				if (found_free_q) begin
					valid_q[free_q] <= 1'b1;
					stime_q[free_q] <= item_q.now_ms;
					ltry_q[free_q] <= '0;
					trynow_q[free_q] <= 1'b1;
					fail_q[free_q] <= '0;
					dest_q[free_q] <= item_q.dest_address;
					mid_q[free_q] <= item_q.message_id;
					tag_q[free_q] <= item_q.packet_tag;
					res <= '{kind: KIND_ENQ, slot: 4'(free_q), out_dest_address: 16'd0,
						out_message_id: 32'd0, out_packet_tag: 32'd0, outcome: OUT_OK,
						last: 1'b1};
				end else begin
					stime_q[best_q] <= item_q.now_ms;
					ltry_q[best_q] <= '0;
					trynow_q[best_q] <= 1'b1;
					fail_q[best_q] <= '0;
					dest_q[best_q] <= item_q.dest_address;
					mid_q[best_q] <= item_q.message_id;
					tag_q[best_q] <= item_q.packet_tag;
					res <= '{kind: KIND_ENQ, slot: 4'(best_q), out_dest_address: 16'd0,
						out_message_id: 32'd0, out_packet_tag: 32'd0, outcome: OUT_EVICT,
						last: 1'b1};
				end
			end
			if (cmd.do_route) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (valid_q[i] && dest_q[i] == item_q.dest_address) trynow_q[i] <= 1'b1;
				end
				res <= '{kind: KIND_ROUTE, slot: 4'd0, out_dest_address: 16'd0,
					out_message_id: 32'd0, out_packet_tag: 32'd0, outcome: OUT_OK,
					last: 1'b1};
			end
			if (cmd.visit) begin
				seen_q[best_q] <= 1'b1;
				idx_q <= '0;
				best_vld_q <= 1'b0;
				if (expired) begin
					valid_q[best_q] <= 1'b0;
				end else if (!in_window && 32'(att_q) < MAX_ATTEMPTS) begin
					attempt_q <= 1'b1;
					att_q <= att_q + 5'd1;
					ltry_q[best_q] <= item_q.now_ms;
					trynow_q[best_q] <= 1'b0;
					res.kind <= KIND_ATT;
					res.slot <= 4'(best_q);
					res.out_dest_address <= dest_q[best_q];
					res.out_message_id <= mid_q[best_q];
					res.out_packet_tag <= tag_q[best_q];
					res.last <= 1'b0;
					if (ok) begin
						valid_q[best_q] <= 1'b0;
						res.outcome <= OUT_OK;
					end else begin
						fail_q[best_q] <= fail_nx;
						if (fail_nx > {1'b0, max_retries}) begin
							valid_q[best_q] <= 1'b0;
							res.outcome <= OUT_DROP;
						end else begin
							res.outcome <= OUT_KEEP;
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/rqbs_ctrl.sv
// ----------------------------------------------------------------------------
// Retry queue controller
// Sequences enqueue scan, route marking and age-ordered tick visits.
// ----------------------------------------------------------------------------
`default_nettype none
module rqbs_ctrl
	import rqbs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [1:0] in_command,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output logic out_done_sel,
	output dp_cmd_t cmd,
	input wire dp_sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_ESCAN, S_EWRITE, S_ROUTE, S_PICK, S_VISIT, S_VCHK, S_DONE_OR_ATT,
		S_DONE, S_OUT
	} state_t;
	state_t state_q, ret_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready && (in_command == CMD_ENQ
			|| in_command == CMD_TICK || in_command == CMD_ROUTE);
		case (state_q)
			S_ESCAN: cmd.scan_step = 1'b1;
			S_EWRITE: cmd.do_enq = 1'b1;
			S_ROUTE: cmd.do_route = 1'b1;
			S_PICK: cmd.pick = 1'b1;
			S_VISIT: cmd.visit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			out_valid <= 1'b0;
			out_done_sel <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						case (in_command)
							CMD_ENQ: state_q <= S_ESCAN;
							CMD_TICK: state_q <= S_PICK;
							default: state_q <= S_ROUTE;
						endcase
					end
				end
				S_ESCAN: if (sts.scan_done) state_q <= S_EWRITE;
				S_EWRITE, S_ROUTE: begin
					out_valid <= 1'b1;
					out_done_sel <= 1'b0;
					ret_q <= S_IDLE;
					state_q <= S_OUT;
				end
				S_PICK: if (sts.scan_done) state_q <= S_VCHK;
				S_VCHK: state_q <= sts.any_left ? S_VISIT : S_DONE;
				S_VISIT: state_q <= S_DONE_OR_ATT;
				S_DONE_OR_ATT: begin
					if (sts.attempt) begin
						out_valid <= 1'b1;
						out_done_sel <= 1'b0;
						ret_q <= S_PICK;
						state_q <= S_OUT;
					end else begin
						state_q <= S_PICK;
					end
				end
				S_DONE: begin
					out_valid <= 1'b1;
					out_done_sel <= 1'b1;
					ret_q <= S_IDLE;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/retry_queue_backoff_scheduler.sv
// ----------------------------------------------------------------------------
// Retry queue with exponential backoff
// Top level: configuration registers, controller and slot datapath.
// ----------------------------------------------------------------------------
// One item at a time. An enqueue scans all SLOTS slots one per cycle, then
// writes. A tick repeatedly scans SLOTS slots to find the oldest unvisited
// valid one, then visits it; the search for the oldest slot is serial. Each
// result beat waits in the output register until taken.
`default_nettype none
`include "retry_queue_backoff_scheduler_defines.svh"
module retry_queue_backoff_scheduler
	import rqbs_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rqbs_stream_if.sink in_ch,
	rqbs_stream_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [30:0] cfg_data
);
	logic [30:0] max_age_q;
	logic [3:0] max_retries_q;
	logic [15:0] base_backoff_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	out_item_t res;
	logic done_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RST;
			max_retries_q <= MAX_RETRIES_RST;
			base_backoff_q <= BASE_BACKOFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_AGE: max_age_q <= cfg_data;
				REG_MAX_RETRIES: max_retries_q <= cfg_data[3:0];
				REG_BASE_BACKOFF: base_backoff_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rqbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_command(in_ch.data.command), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_done_sel(done_sel),
		.cmd(cmd), .sts(sts)
	);

	rqbs_datapath #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .item(in_ch.data),
		.max_age_ms(max_age_q), .max_retries(max_retries_q),
		.base_backoff_ms(base_backoff_q), .res(res)
	);

	always_comb begin
		out_ch.data = res;
		if (done_sel) begin
			out_ch.data = '0;
			out_ch.data.kind = KIND_DONE;
			out_ch.data.last = 1'b1;
		end
	end

	`RQ_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_ch.valid, !in_ch.ready)
	`RQ_ASSERT_IMPL(a_last_kinds, clk, arst_n, out_ch.valid && out_ch.data.kind == KIND_ATT,
		!out_ch.data.last)
	`RQ_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
`default_nettype wire

>>> bench/retry_queue_backoff_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Retry queue scheduler testbench
// Drives enqueue, tick and route-found items through the input stream with
// bursty gaps, predicts every result beat from a local copy of the slot
// table, and checks the output stream field by field under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module retry_queue_backoff_scheduler_tb
	import rqbs_pkg::*;
();

	localparam int NSLOT = 16;
	localparam int SETTLE_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;

	rqbs_stream_if #(.payload_t(in_item_t)) in_ch ();
	rqbs_stream_if #(.payload_t(out_item_t)) out_ch ();

	retry_queue_backoff_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// local copy of the slot table and registers
	logic [30:0] max_age_q;
	logic [3:0] max_retries_q;
	logic [15:0] base_backoff_q;
	bit slot_used [NSLOT];
	logic [31:0] slot_stored [NSLOT];
	logic [31:0] slot_last_try [NSLOT];
	bit slot_try_now [NSLOT];
	logic [4:0] slot_fails [NSLOT];
	logic [15:0] slot_dest_q [NSLOT];
	logic [31:0] slot_mid_q [NSLOT];
	logic [31:0] slot_tag_q [NSLOT];

	out_item_t expected_beats [$];
	int errors;
	longint cycles;
	int burst_left;
	logic [31:0] clock_ms;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL retry_queue_backoff_scheduler");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic out_item_t make_beat(input logic [1:0] kind, input logic [3:0] slot,
			input logic [15:0] dest, input logic [31:0] mid, input logic [31:0] tag,
			input logic [1:0] outcome, input logic last);
		out_item_t b;
		b.kind = kind;
		b.slot = slot;
		b.out_dest_address = dest;
		b.out_message_id = mid;
		b.out_packet_tag = tag;
		b.outcome = outcome;
		b.last = last;
		return b;
	endfunction

	task automatic predict_results(input in_item_t it);
		int order [NSLOT];
		int count;
		int attempts;
		int target;
		int oldest;
		int cur;
		int b;
		int s;
		logic [31:0] age;
		logic [31:0] best_age;
		logic [63:0] wide_delay;
		logic [1:0] outcome;
		count = 0;
		attempts = 0;
		target = -1;
		oldest = -1;
		best_age = '0;
		case (it.command)
			CMD_ENQ: begin
				outcome = OUT_OK;
				for (int i = 0; i < NSLOT; i++) begin
					if (!slot_used[i]) begin
						target = i;
						break;
					end
					age = it.now_ms - slot_stored[i];
					if (oldest < 0 || age > best_age) begin
						best_age = age;
						oldest = i;
					end
				end
				if (target < 0) begin
					target = oldest;
					outcome = OUT_EVICT;
				end
				slot_used[target] = 1'b1;
				slot_stored[target] = it.now_ms;
				slot_last_try[target] = '0;
				slot_try_now[target] = 1'b1;
				slot_fails[target] = '0;
				slot_dest_q[target] = it.dest_address;
				slot_mid_q[target] = it.message_id;
				slot_tag_q[target] = it.packet_tag;
				expected_beats.push_back(make_beat(KIND_ENQ, target[3:0], '0, '0, '0,
					outcome, 1'b1));
			end
			CMD_TICK: begin
				for (int i = 0; i < NSLOT; i++)
					if (slot_used[i]) order[count++] = i;
				for (int a = 1; a < count; a++) begin
					cur = order[a];
					age = it.now_ms - slot_stored[cur];
					b = a;
					while (b > 0 && (it.now_ms - slot_stored[order[b - 1]]) < age) begin
						order[b] = order[b - 1];
						b--;
					end
					order[b] = cur;
				end
				for (int a = 0; a < count; a++) begin
					s = order[a];
					age = it.now_ms - slot_stored[s];
					if (!age[31] && age >= {1'b0, max_age_q}) begin
						slot_used[s] = 1'b0;
						continue;
					end
					wide_delay = {48'd0, base_backoff_q} << slot_fails[s];
					if (!slot_try_now[s] && (it.now_ms - slot_last_try[s]) < wide_delay[31:0])
						continue;
					if (attempts >= MAX_ATTEMPTS) continue;
					slot_last_try[s] = it.now_ms;
					slot_try_now[s] = 1'b0;
					if (it.send_ok_mask[s]) begin
						slot_used[s] = 1'b0;
						outcome = OUT_OK;
					end else begin
						if (slot_fails[s] < 5'd31) slot_fails[s]++;
						if (slot_fails[s] > {1'b0, max_retries_q}) begin
							slot_used[s] = 1'b0;
							outcome = OUT_DROP;
						end else begin
							outcome = OUT_KEEP;
						end
					end
					expected_beats.push_back(make_beat(KIND_ATT, s[3:0], slot_dest_q[s],
						slot_mid_q[s], slot_tag_q[s], outcome, 1'b0));
					attempts++;
				end
				expected_beats.push_back(make_beat(KIND_DONE, '0, '0, '0, '0, OUT_OK, 1'b1));
			end
			CMD_ROUTE: begin
				for (int i = 0; i < NSLOT; i++)
					if (slot_used[i] && slot_dest_q[i] == it.dest_address)
						slot_try_now[i] = 1'b1;
				expected_beats.push_back(make_beat(KIND_ROUTE, '0, '0, '0, '0, OUT_OK, 1'b1));
			end
			default: ;
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("unexpected beat kind", 32'(out_ch.data.kind), '0);
			end else begin
				want = expected_beats.pop_front();
				if (out_ch.data.kind !== want.kind)
					report_mismatch("kind", 32'(out_ch.data.kind), 32'(want.kind));
				if (out_ch.data.slot !== want.slot)
					report_mismatch("slot", 32'(out_ch.data.slot), 32'(want.slot));
				if (out_ch.data.out_dest_address !== want.out_dest_address)
					report_mismatch("out_dest_address", 32'(out_ch.data.out_dest_address),
						32'(want.out_dest_address));
				if (out_ch.data.out_message_id !== want.out_message_id)
					report_mismatch("out_message_id", out_ch.data.out_message_id,
						want.out_message_id);
				if (out_ch.data.out_packet_tag !== want.out_packet_tag)
					report_mismatch("out_packet_tag", out_ch.data.out_packet_tag,
						want.out_packet_tag);
				if (out_ch.data.outcome !== want.outcome)
					report_mismatch("outcome", 32'(out_ch.data.outcome), 32'(want.outcome));
				if (out_ch.data.last !== want.last)
					report_mismatch("last", 32'(out_ch.data.last), 32'(want.last));
			end
		end
	end

	// receiver stall pattern: rotates through four ready modes
	always @(negedge clk) begin
		int mode;
		mode = int'((cycles / 64) % 4);
		case (mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			2: out_ch.ready <= ($urandom_range(0, 3) == 0);
			default: out_ch.ready <= ((cycles % 5) != 4);
		endcase
	end

	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		predict_results(it);
		burst_left--;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [30:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_MAX_AGE: max_age_q = value;
			REG_MAX_RETRIES: max_retries_q = value[3:0];
			REG_BASE_BACKOFF: base_backoff_q = value[15:0];
			default: ;
		endcase
	endtask

	function automatic in_item_t build_item(input logic [1:0] cmd, input logic [31:0] now,
			input logic [15:0] dest, input logic [31:0] mid, input logic [31:0] tag,
			input logic [15:0] mask);
		in_item_t it;
		it.command = cmd;
		it.now_ms = now;
		it.dest_address = dest;
		it.message_id = mid;
		it.packet_tag = tag;
		it.send_ok_mask = mask;
		return it;
	endfunction

	task automatic test_directed();
		logic [15:0] dest;
		for (int i = 0; i < NSLOT; i++) begin
			dest = 16'(i * 16'h1111);
			send_item(build_item(CMD_ENQ, (i < 8) ? 32'd1000 : 32'd2000, dest,
				(i % 2) ? 32'hffff_ffff : 32'h0, (i % 2) ? 32'h0 : 32'hffff_ffff, 16'h0));
		end
		// full table: evict oldest, tie to lower index
		send_item(build_item(CMD_ENQ, 32'd3000, 16'hffff, 32'h1234_5678, 32'h8765_4321, 16'h0));
		send_item(build_item(CMD_TICK, 32'd3000, 16'h0, 32'h0, 32'h0, 16'h00ff));
		send_item(build_item(CMD_TICK, 32'd4000, 16'h0, 32'h0, 32'h0, 16'h0000));
		send_item(build_item(CMD_ROUTE, 32'd4000, 16'h8888, 32'h0, 32'h0, 16'h0));
		send_item(build_item(CMD_TICK, 32'd4000, 16'h0, 32'h0, 32'h0, 16'h0000));
		send_item(build_item(CMD_UNUSED, 32'hffff_ffff, 16'hffff, 32'hffff_ffff,
			32'hffff_ffff, 16'hffff));
		send_item(build_item(CMD_ENQ, 32'd700000, 16'h0042, 32'h5555_aaaa, 32'haaaa_5555,
			16'h0));
		// stored time in the future never expires
		send_item(build_item(CMD_TICK, 32'd610000, 16'h0, 32'h0, 32'h0, 16'hffff));
		send_item(build_item(CMD_TICK, 32'hffff_ffff, 16'h0, 32'h0, 32'h0, 16'h0));
	endtask

	task automatic test_random_phase(input int count);
		int sent;
		int pick;
		logic [1:0] cmd;
		logic [15:0] dest;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			cmd = (pick < 40) ? CMD_ENQ : (pick < 75) ? CMD_TICK :
				(pick < 95) ? CMD_ROUTE : CMD_UNUSED;
			pick = $urandom_range(0, 99);
			if (pick < 4) clock_ms = $urandom;
			else if (pick < 8) clock_ms = clock_ms - $urandom_range(0, 5000);
			else clock_ms = clock_ms + $urandom_range(0, 4000);
			dest = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
			send_item(build_item(cmd, clock_ms, dest, $urandom, $urandom, 16'($urandom)));
			if (cmd != CMD_UNUSED) sent++;
			if (sent == count / 2 && cmd != CMD_UNUSED) drain_results();
		end
	endtask

	task automatic test_default_registers();
		test_random_phase(90);
	endtask

	task automatic test_widest_settings();
		write_register(REG_MAX_AGE, 31'h7fff_ffff);
		write_register(REG_MAX_RETRIES, 31'd15);
		write_register(REG_BASE_BACKOFF, 31'd1);
		test_random_phase(70);
	endtask

	task automatic test_instant_expiry();
		write_register(REG_MAX_AGE, 31'd0);
		write_register(REG_MAX_RETRIES, 31'd0);
		write_register(REG_BASE_BACKOFF, 31'd65535);
		test_random_phase(40);
	endtask

	task automatic test_short_window();
		write_register(REG_MAX_AGE, 31'd30000);
		write_register(REG_MAX_RETRIES, 31'd2);
		write_register(REG_BASE_BACKOFF, 31'd1000);
		test_random_phase(90);
	endtask

	task automatic test_long_backoff();
		write_register(REG_MAX_AGE, 31'd1);
		write_register(REG_MAX_AGE, 31'h4000_0000);
		write_register(REG_MAX_RETRIES, 31'd15);
		write_register(REG_BASE_BACKOFF, 31'd65535);
		test_random_phase(70);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		clock_ms = 32'd5000;
		max_age_q = MAX_AGE_RST;
		max_retries_q = MAX_RETRIES_RST;
		base_backoff_q = BASE_BACKOFF_RST;
		for (int i = 0; i < NSLOT; i++) begin
			slot_used[i] = 1'b0;
			slot_stored[i] = '0;
			slot_last_try[i] = '0;
			slot_try_now[i] = 1'b0;
			slot_fails[i] = '0;
			slot_dest_q[i] = '0;
			slot_mid_q[i] = '0;
			slot_tag_q[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_default_registers();
		test_widest_settings();
		test_instant_expiry();
		test_short_window();
		test_long_backoff();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("PASS retry_queue_backoff_scheduler");
		end else begin
			$display("FAIL retry_queue_backoff_scheduler");
		end
		$finish;
	end
endmodule
`default_nettype wire
